/* design/banked_page_allocator_refcount_core_defines.svh */
// assertion macros for the page allocator
`ifndef BANKED_PAGE_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH
`define BANKED_PAGE_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BPA_ASSERT(label, clk_i, rst_i, prop) \
    label: assert property (@(posedge clk_i) disable iff (!rst_i) prop) \
        else $error("assertion failed");
`define BPA_ASSERT_RST(label, clk_i, prop) \
    label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define BPA_ASSERT(label, clk_i, rst_i, prop)
`define BPA_ASSERT_RST(label, clk_i, prop)
`endif
`endif

/* design/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and codes of the banked page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_ADDREF = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR = 3'd2;
    localparam logic [2:0] ST_STILL_REF = 3'd3;
    localparam logic [2:0] ST_DBL_FREE = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_END_PAGE   = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  requester;
        logic [31:0] phys_addr;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] page_addr;
        logic [2:0]  bank_used;
        logic        stolen;
        logic [7:0]  ref_after;
    } rsp_t;

endpackage

/* design/banked_page_allocator_refcount_core.sv */
// ----------------------------------------------------------------------------
// banked_page_allocator_refcount_core
// banked lifo page allocator with per-page reference counts
// ----------------------------------------------------------------------------
// usage: requests arrive on req (valid/ready), one result per request leaves
// on rsp (valid/ready). configuration writes use cfg (index 0 first_page,
// index 1 end_page) and are taken only while no request is in flight; a
// pending configuration write goes ahead of a waiting request.
// a request is handled by one sequencer sharing one offset adder/compare
// and one read and one write port per memory, so only one request is in
// flight at a time. free / add reference check the address, then update
// the count; allocate probes the banks from the home bank on until one is
// not empty (out of memory if none); init clears every count, then pushes
// each frame of the range onto its bank.
// the result sits in an output register; while the receiver stalls the
// block holds it and takes no new request until the transfer completes,
// then it returns to idle to take the next request.
// reset empties every bank (stack levels zero) and loads the register
// reset values; stack slots and counts stay undefined until init.
// ----------------------------------------------------------------------------
`include "banked_page_allocator_refcount_core_defines.svh"

module banked_page_allocator_refcount_core #(
    parameter int NUM_BANKS = 8,
    parameter int NUM_PAGES = 32768
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bpa_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bpa_pkg::rsp_t  rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [20:0]    cfg_data
);
    import bpa_pkg::*;

    localparam int BANK_DEPTH = (NUM_PAGES + NUM_BANKS - 1) / NUM_BANKS;
    localparam int OFF_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int SLOT_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LVL_W  = $clog2(BANK_DEPTH + 1);
    localparam int MEM_D  = NUM_BANKS * BANK_DEPTH;
    localparam int MEM_W  = $clog2(MEM_D);
    localparam logic [21:0] NP22 = 22'(NUM_PAGES);
    localparam logic [20:0] PAGE_SPAN = 21'h100000;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_PUSH, S_PROBE, S_AREAD, S_AUPD,
        S_FREAD, S_FUPD, S_RESP
    } state_t;

    state_t            state_reg;
    logic [19:0]       first_reg;
    logic [20:0]       end_reg;
    logic [LVL_W-1:0]  lvl_reg [NUM_BANKS];
    req_t              req_reg;
    rsp_t              rsp_reg;
    logic [20:0]       page_reg;     // running page number or request page
    logic [20:0]       eff_end_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [BANK_W-1:0] bank_reg;
    logic [BANK_W-1:0] home_reg;
    logic [BANK_W:0]   probe_reg;    // banks probed so far
    logic [BANK_W-1:0] pbank_reg;    // bank of running page during init, of the freed page otherwise

    // memories
    logic [OFF_W-1:0]  stack_mem [MEM_D];
    logic [7:0]        cnt_mem [NUM_PAGES];
    logic [OFF_W-1:0]  stack_rd;
    logic [7:0]        cnt_rd;
    logic              stack_we, cnt_we;
    logic [MEM_W-1:0]  stack_wa, stack_ra;
    logic [OFF_W-1:0]  stack_wd;
    logic [OFF_W-1:0]  cnt_wa, cnt_ra;
    logic [7:0]        cnt_wd;

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_rd <= stack_mem[stack_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_ra];
    end

    // shared offset unit: page minus first page
    logic [21:0] diff;
    logic [OFF_W-1:0] rel_off;
    assign diff = {1'b0, page_reg} - {2'b0, first_reg};
    assign rel_off = diff[OFF_W-1:0];

    function automatic logic [MEM_W-1:0] slot_addr(input logic [BANK_W-1:0] b,
                                                   input logic [LVL_W-1:0] l);
        slot_addr = MEM_W'(MEM_W'(b) * MEM_W'(BANK_DEPTH) + MEM_W'(l));
    endfunction

    function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] b);
        bank_inc = (32'(b) == NUM_BANKS - 1) ? '0 : BANK_W'(b + 1'b1);
    endfunction

    // end of range: least of end_page, capacity and the page space
    logic [21:0] cap;
    logic [20:0] eff_end;
    always_comb
    begin
        cap = {2'b0, first_reg} + NP22;
        eff_end = end_reg;
        if (cap < {1'b0, eff_end})
        begin
            eff_end = cap[20:0];
        end
        if (eff_end > PAGE_SPAN)
        begin
            eff_end = PAGE_SPAN;
        end
    end

    logic [LVL_W-1:0] plvl;
    logic [LVL_W-1:0] blvl;
    assign plvl = lvl_reg[pbank_reg];
    assign blvl = lvl_reg[bank_reg];

    logic push_ok;
    assign push_ok = 32'(plvl) < BANK_DEPTH;

    assign req_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp = rsp_reg;

    // memory port control
    always_comb
    begin
        stack_we = 1'b0;
        stack_wa = slot_addr(pbank_reg, plvl);
        stack_wd = rel_off;
        stack_ra = slot_addr(bank_reg, blvl - 1'b1);
        cnt_we = 1'b0;
        cnt_wa = off_reg;
        cnt_wd = '0;
        cnt_ra = rel_off;
        unique case (state_reg)
            S_CLR:
            begin
                cnt_we = 1'b1;
                cnt_wa = off_reg;
                cnt_wd = '0;
            end
            S_PUSH:
            begin
                stack_we = (page_reg < eff_end_reg) && push_ok;
            end
            S_AREAD:
            begin
                cnt_ra = stack_rd;
            end
            S_AUPD:
            begin
                cnt_we = 1'b1;
                cnt_wd = (cnt_rd == 8'hff) ? cnt_rd : cnt_rd + 8'd1;
            end
            S_FUPD:
            begin
                if (req_reg.req_type == REQ_FREE)
                begin
                    cnt_we = (cnt_rd != 8'd0);
                    cnt_wd = cnt_rd - 8'd1;
                    stack_we = (cnt_rd == 8'd1) && push_ok;
                end
                else
                begin
                    cnt_we = (cnt_rd != 8'hff);
                    cnt_wd = cnt_rd + 8'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 20'd524288;
            end_reg   <= 21'd557056;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                lvl_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_FIRST_PAGE)
                        begin
                            first_reg <= cfg_data[19:0];
                        end
                        else
                        begin
                            end_reg <= cfg_data;
                        end
                    end
                    else if (req_valid)
                    begin
                        req_reg <= req;
                        rsp_reg <= '0;
                        page_reg <= {1'b0, req.phys_addr[31:12]};
                        eff_end_reg <= eff_end;
                        home_reg <= BANK_W'(32'(req.requester) % NUM_BANKS);
                        bank_reg <= BANK_W'(32'(req.requester) % NUM_BANKS);
                        probe_reg <= '0;
                        off_reg <= '0;
                        unique case (req.req_type)
                            REQ_INIT:
                            begin
                                for (int i = 0; i < NUM_BANKS; i++)
                                begin
                                    lvl_reg[i] <= '0;
                                end
                                state_reg <= S_CLR;
                            end
                            REQ_ALLOC:
                            begin
                                state_reg <= S_PROBE;
                            end
                            default:
                            begin
                                state_reg <= S_FREAD;
                            end
                        endcase
                    end
                end
                S_CLR:
                begin
                    // clear one count per cycle
                    off_reg <= off_reg + 1'b1;
                    if (32'(off_reg) == NUM_PAGES - 1)
                    begin
                        page_reg <= {1'b0, first_reg};
                        pbank_reg <= BANK_W'(32'(first_reg) % NUM_BANKS);
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (page_reg < eff_end_reg)
                    begin
                        if (push_ok)
                        begin
                            lvl_reg[pbank_reg] <= plvl + 1'b1;
                        end
                        page_reg <= page_reg + 1'b1;
                        pbank_reg <= bank_inc(pbank_reg);
                    end
                    else
                    begin
                        rsp_reg.status <= ST_OK;
                        state_reg <= S_RESP;
                    end
                end
                S_PROBE:
                begin
                    if (blvl != '0)
                    begin
                        lvl_reg[bank_reg] <= blvl - 1'b1;
                        state_reg <= S_AREAD;
                    end
                    else if (32'(probe_reg) == NUM_BANKS - 1)
                    begin
                        rsp_reg.status <= ST_OOM;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        probe_reg <= probe_reg + 1'b1;
                        bank_reg <= bank_inc(bank_reg);
                    end
                end
                S_AREAD:
                begin
                    off_reg <= stack_rd;
                    state_reg <= S_AUPD;
                end
                S_AUPD:
                begin
                    rsp_reg.status <= ST_OK;
                    rsp_reg.page_addr <= {first_reg + 20'(off_reg), 12'h000};
                    rsp_reg.bank_used <= 3'(bank_reg);
                    rsp_reg.stolen <= (bank_reg != home_reg);
                    rsp_reg.ref_after <= cnt_wd;
                    state_reg <= S_RESP;
                end
                S_FREAD:
                begin
                    off_reg <= rel_off;
                    pbank_reg <= BANK_W'(32'(page_reg) % NUM_BANKS);
                    if (req_reg.phys_addr[11:0] != 12'h000 || diff[21]
                        || page_reg >= eff_end_reg)
                    begin
                        rsp_reg.status <= ST_BAD_ADDR;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_FUPD;
                    end
                end
                S_FUPD:
                begin
                    rsp_reg.ref_after <= cnt_we ? cnt_wd : cnt_rd;
                    if (req_reg.req_type == REQ_FREE)
                    begin
                        if (cnt_rd == 8'd0)
                        begin
                            rsp_reg.status <= ST_DBL_FREE;
                        end
                        else if (cnt_rd != 8'd1)
                        begin
                            rsp_reg.status <= ST_STILL_REF;
                        end
                        else if (push_ok)
                        begin
                            lvl_reg[pbank_reg] <= plvl + 1'b1;
                        end
                    end
                    else if (cnt_rd == 8'hff)
                    begin
                        rsp_reg.status <= ST_OVERFLOW;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (rsp_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `BPA_ASSERT(a_rsp_only_resp, clk, rst_n, rsp_valid |-> !req_ready)
    `BPA_ASSERT(a_status_range, clk, rst_n, rsp_valid |-> rsp.status <= ST_OVERFLOW)
    `BPA_ASSERT(a_oom_zero, clk, rst_n, (rsp_valid && rsp.status == ST_OOM) |-> rsp.page_addr == 32'd0)
    `BPA_ASSERT_RST(a_reset_idle, clk, !rst_n |-> !rsp_valid)

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the banked page allocator: a behavioral copy of
// the free stacks and reference counts predicts every result, and random
// gaps, stalls and one long receiver hold-off exercise the handshakes
// ----------------------------------------------------------------------------
module tb;
    import bpa_pkg::*;

    localparam int BANKS      = 8;
    localparam int FRAMES     = 32768;
    localparam int BANK_SLOTS = (FRAMES + BANKS - 1) / BANKS;
    localparam longint PAGE_SPAN = 64'd1048576;

    // where a free / add reference takes its address from
    localparam logic [1:0] SRC_GIVEN     = 2'd0;
    localparam logic [1:0] SRC_ANY_LIVE  = 2'd1;
    localparam logic [1:0] SRC_LAST_LIVE = 2'd2;

    typedef struct {
        req_t       r;
        logic [1:0] src;
    } item_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [20:0] cfg_data;

    // shadow allocator state
    logic [14:0] slot_mem [BANKS][BANK_SLOTS];
    int unsigned fill_lvl [BANKS];
    logic [7:0]  ref_cnt  [FRAMES];
    logic [19:0] sh_first;
    logic [20:0] sh_end;

    item_t       req_backlog [$];
    rsp_t        pending_rsp [$];
    logic [31:0] live_addrs  [$];

    int          mismatches;
    int          xfers_in;
    int          xfers_out;
    int          gap_left;
    int          stall_left;
    int          holdoff_left;
    bit          holdoff_done;
    bit          quiet;
    int          n_oom, n_steal, n_ovf, n_dbl, n_bad;

    banked_page_allocator_refcount_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // effective end of the managed range
    function automatic longint range_end();
        longint e;
        e = sh_end;
        if (longint'(sh_first) + FRAMES < e)
            e = longint'(sh_first) + FRAMES;
        if (e > PAGE_SPAN)
            e = PAGE_SPAN;
        return e;
    endfunction

    function automatic void push_frame(longint page);
        int          b;
        logic [31:0] rel;
        b = int'(page % BANKS);
        if (fill_lvl[b] >= BANK_SLOTS)
            return;
        rel = 32'(page) - 32'(sh_first);
        slot_mem[b][fill_lvl[b]] = rel[14:0];
        fill_lvl[b]++;
    endfunction

    // result of one request against the shadow state, updating it
    function automatic rsp_t frame_outcome(req_t r);
        rsp_t        o;
        int          home, b;
        bit          got;
        logic [14:0] off;
        logic [31:0] rel;
        longint      page;
        logic [7:0]  c;
        o = '0;
        case (r.req_type)
            REQ_INIT:
            begin
                for (int i = 0; i < FRAMES; i++)
                    ref_cnt[i] = '0;
                for (int i = 0; i < BANKS; i++)
                    fill_lvl[i] = 0;
                for (longint p = sh_first; p < range_end(); p++)
                    push_frame(p);
                live_addrs.delete();
            end
            REQ_ALLOC:
            begin
                home = r.requester % BANKS;
                got  = 1'b0;
                b    = home;
                for (int i = 0; i < BANKS && !got; i++)
                begin
                    b = (home + i) % BANKS;
                    if (fill_lvl[b] != 0)
                    begin
                        fill_lvl[b]--;
                        off = slot_mem[b][fill_lvl[b]];
                        got = 1'b1;
                    end
                end
                if (!got)
                    o.status = ST_OOM;
                else
                begin
                    if (ref_cnt[off] != 8'hff)
                        ref_cnt[off]++;
                    o.ref_after = ref_cnt[off];
                    o.page_addr = 32'((longint'(sh_first) + off) << 12);
                    o.bank_used = 3'(b);
                    o.stolen    = (b != home);
                    live_addrs.push_back(o.page_addr);
                    if (live_addrs.size() > 64)
                        void'(live_addrs.pop_front());
                end
            end
            default:
            begin
                page = r.phys_addr >> 12;
                if (r.phys_addr[11:0] != 0 || page < sh_first || page >= range_end())
                    o.status = ST_BAD_ADDR;
                else
                begin
                    rel = 32'(page) - 32'(sh_first);
                    off = rel[14:0];
                    c   = ref_cnt[off];
                    if (r.req_type == REQ_FREE)
                    begin
                        if (c == 0)
                            o.status = ST_DBL_FREE;
                        else
                        begin
                            c--;
                            ref_cnt[off] = c;
                            if (c != 0)
                                o.status = ST_STILL_REF;
                            else
                                push_frame(page);
                        end
                    end
                    else if (c == 8'hff)
                        o.status = ST_OVERFLOW;
                    else
                        ref_cnt[off] = c + 8'd1;
                    o.ref_after = ref_cnt[off];
                end
            end
        endcase
        return o;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, xfers_out);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // request driver: one item at a time from the backlog, random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        item_t it;
        bit    busy;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left  = 0;
        end
        else
        begin
            busy = req_valid;
            if (req_valid && req_ready)
            begin
                // transfer: predict now, state is current
                pending_rsp.push_back(frame_outcome(req));
                xfers_in++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    it = req_backlog.pop_front();
                    // live addresses are resolved against the state right now
                    if (it.src != SRC_GIVEN && live_addrs.size() != 0)
                    begin
                        if (it.src == SRC_LAST_LIVE)
                            it.r.phys_addr = live_addrs[live_addrs.size() - 1];
                        else
                            it.r.phys_addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
                    end
                    req       <= it.r;
                    req_valid <= 1'b1;
                    gap_left  = quiet ? 0 : pick_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // ------------------------------------------------------------------------
    // long receiver hold-off, once, in the middle of the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            holdoff_left = 0;
            holdoff_done = 1'b0;
        end
        else if (!holdoff_done && xfers_in >= 400)
        begin
            holdoff_left = 300;
            holdoff_done = 1'b1;
        end
        else if (holdoff_left > 0)
            holdoff_left--;
    end

    // ------------------------------------------------------------------------
    // result monitor: compare against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                xfers_out++;
                if (pending_rsp.size() == 0)
                begin
                    $display("unexpected result transfer %0d", xfers_out);
                    mismatches++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.status != want.status)
                        flag_mismatch("status", rsp.status, want.status);
                    if (rsp.page_addr != want.page_addr)
                        flag_mismatch("page_addr", rsp.page_addr, want.page_addr);
                    if (rsp.bank_used != want.bank_used)
                        flag_mismatch("bank_used", rsp.bank_used, want.bank_used);
                    if (rsp.stolen != want.stolen)
                        flag_mismatch("stolen", rsp.stolen, want.stolen);
                    if (rsp.ref_after != want.ref_after)
                        flag_mismatch("ref_after", rsp.ref_after, want.ref_after);
                    case (want.status)
                        ST_OOM:      n_oom++;
                        ST_OVERFLOW: n_ovf++;
                        ST_DBL_FREE: n_dbl++;
                        ST_BAD_ADDR: n_bad++;
                        default:     if (want.stolen) n_steal++;
                    endcase
                end
            end
            if (holdoff_left > 0)
                rsp_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall_left = quiet ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic item_t mk(logic [1:0] kind, logic [2:0] who, logic [31:0] addr,
                                 logic [1:0] src);
        item_t it;
        it.r.req_type  = kind;
        it.r.requester = who;
        it.r.phys_addr = addr;
        it.src         = src;
        return it;
    endfunction

    // page-aligned address near the managed range, sometimes misaligned
    function automatic logic [31:0] near_range_addr();
        longint page;
        logic [31:0] a;
        page = longint'(sh_first) - 2 + $urandom_range(
            int'(range_end() > sh_first ? range_end() - sh_first : 0) + 4);
        if (page < 0)
            page = 0;
        a = 32'(page << 12);
        if ($urandom_range(9) == 0)
            a[11:0] = 12'($urandom_range(4095, 1));
        return a;
    endfunction

    function automatic item_t random_item();
        int roll;
        roll = $urandom_range(99);
        if (roll < 38)
            return mk(REQ_ALLOC, 3'($urandom), 32'($urandom), SRC_GIVEN);
        if (roll < 85)
            return mk(roll < 68 ? REQ_FREE : REQ_ADDREF, 3'($urandom), near_range_addr(),
                      $urandom_range(3) != 0 ? SRC_ANY_LIVE : SRC_GIVEN);
        // noise: any address at all
        return mk(roll < 93 ? REQ_FREE : REQ_ADDREF, 3'($urandom), 32'($urandom), SRC_GIVEN);
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || req_valid || pending_rsp.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [20:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FIRST_PAGE)
            sh_first = val[19:0];
        else
            sh_end = val;
        @(posedge clk);
    endtask

    task automatic phase(logic [20:0] first, logic [20:0] last, bit do_init, int n_rand);
        write_reg(CFG_FIRST_PAGE, first);
        write_reg(CFG_END_PAGE, last);
        @(posedge clk);
        if (do_init)
            req_backlog.push_back(mk(REQ_INIT, 3'd0, 32'd0, SRC_GIVEN));
        repeat (n_rand)
            req_backlog.push_back(random_item());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FIRST_PAGE;
        cfg_data  = '0;
        sh_first  = 20'd524288;
        sh_end    = 21'd557056;
        for (int i = 0; i < BANKS; i++)
            fill_lvl[i] = 0;
        mismatches = 0;
        xfers_in   = 0;
        xfers_out  = 0;
        quiet      = 1'b0;
        n_oom = 0; n_steal = 0; n_ovf = 0; n_dbl = 0; n_bad = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: allocate before init finds every bank empty
        req_backlog.push_back(mk(REQ_ALLOC, 3'd7, 32'd0, SRC_GIVEN));
        req_backlog.push_back(mk(REQ_INIT, 3'd0, 32'd0, SRC_GIVEN));
        for (int i = 0; i < 8; i++)
            req_backlog.push_back(mk(REQ_ALLOC, 3'(i), 32'd0, SRC_GIVEN));
        req_backlog.push_back(mk(REQ_ADDREF, 3'd0, 32'd0, SRC_LAST_LIVE));
        req_backlog.push_back(mk(REQ_FREE, 3'd0, 32'd0, SRC_LAST_LIVE));   // still referenced
        req_backlog.push_back(mk(REQ_FREE, 3'd0, 32'd0, SRC_LAST_LIVE));   // back to zero
        req_backlog.push_back(mk(REQ_FREE, 3'd0, 32'd0, SRC_LAST_LIVE));   // double free
        req_backlog.push_back(mk(REQ_FREE, 3'd1, 32'h8000_0001, SRC_GIVEN)); // misaligned
        req_backlog.push_back(mk(REQ_ADDREF, 3'd2, 32'h7FFF_F000, SRC_GIVEN)); // below range
        req_backlog.push_back(mk(REQ_ADDREF, 3'd3, 32'h8800_0000, SRC_GIVEN)); // one past end
        req_backlog.push_back(mk(REQ_FREE, 3'd4, 32'h0000_0000, SRC_GIVEN));
        req_backlog.push_back(mk(REQ_FREE, 3'd5, 32'hFFFF_FFFF, SRC_GIVEN));
        req_backlog.push_back(mk(REQ_ADDREF, 3'd6, 32'h8000_0000, SRC_GIVEN)); // first frame
        req_backlog.push_back(mk(REQ_FREE, 3'd7, 32'h87FF_F000, SRC_GIVEN));   // last frame
        repeat (350)
            req_backlog.push_back(random_item());
        drain();

        // small range: banks run dry, stealing, then count overflow on one page
        write_reg(CFG_FIRST_PAGE, 21'd100);
        write_reg(CFG_END_PAGE, 21'd140);
        @(posedge clk);
        req_backlog.push_back(mk(REQ_INIT, 3'd0, 32'd0, SRC_GIVEN));
        repeat (180)
            req_backlog.push_back(random_item());
        req_backlog.push_back(mk(REQ_ALLOC, 3'd0, 32'd0, SRC_GIVEN));
        repeat (257)
            req_backlog.push_back(mk(REQ_ADDREF, 3'd0, 32'd0, SRC_LAST_LIVE));
        repeat (3)
            req_backlog.push_back(mk(REQ_FREE, 3'd0, 32'd0, SRC_LAST_LIVE));
        drain();

        // range moved without init: old stack offsets against the new base
        phase(21'd120, 21'd200, 1'b0, 80);
        // empty range, no idling on either side
        quiet = 1'b1;
        phase(21'd0, 21'd0, 1'b1, 50);
        quiet = 1'b0;
        // top page only, end clipped to the page space
        phase(21'd1048575, 21'h1FFFFF, 1'b1, 50);
        // end clipped to capacity, every bank full
        phase(21'd0, 21'd1048576, 1'b1, 100);

        $display("tb: %0d requests, %0d results; %0d out of memory, %0d stolen,",
                 xfers_in, xfers_out, n_oom, n_steal);
        $display("tb: %0d overflow, %0d double free, %0d bad address over six ranges",
                 n_ovf, n_dbl, n_bad);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
